/* rtl/i2cm_pkg.sv */
`default_nettype none
package i2cm_pkg;

  localparam int unsigned HP_WIDTH        = 16;
  localparam int unsigned DEF_TIMER_WIDTH = 16;
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam int unsigned BIT_CNT_W       = 4;

  localparam logic [HP_WIDTH-1:0]  DEF_HALF_PERIOD = 16'd250;
  localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE   = 4'd8;

  // command codes on the request channel
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_READ  = 3'd3;
  localparam logic [2:0] CMD_STOP  = 3'd4;

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_START,
    CLS_WRITE,
    CLS_READ,
    CLS_STOP
  } cmd_class_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ST_A,
    PH_ST_B,
    PH_WR_LO,
    PH_WR_HI,
    PH_WA_LO,
    PH_WA_HI,
    PH_RD_LO,
    PH_RD_HI,
    PH_RA_LO,
    PH_RA_HI,
    PH_SP_A,
    PH_SP_B,
    PH_SP_C
  } phase_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       nack_after_read;
    logic       sda_level;
  } cmd_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_bit;
  } res_item_t;

  // classified tick held in the queue
  typedef struct packed {
    cmd_class_t cls;
    logic [7:0] tx_byte;
    logic       nack;
    logic       sda;
  } op_t;

endpackage
`default_nettype wire

/* rtl/i2cm_front.sv */
`default_nettype none
module i2cm_front (
  input  wire i2cm_pkg::cmd_item_t cmd_item,
  input  wire                      cmd_valid,
  output logic                     cmd_stall,
  input  wire                      q_full,
  output i2cm_pkg::op_t            q_wdata,
  output logic                     q_push
);
  import i2cm_pkg::*;

  cmd_class_t cls;

  // unused codes fold into no-op
  always_comb begin
    unique case (cmd_item.command)
      CMD_START: cls = CLS_START;
      CMD_WRITE: cls = CLS_WRITE;
      CMD_READ:  cls = CLS_READ;
      CMD_STOP:  cls = CLS_STOP;
      default:   cls = CLS_NONE;
    endcase
  end

  assign cmd_stall       = q_full;
  assign q_push          = cmd_valid & ~q_full;
  assign q_wdata.cls     = cls;
  assign q_wdata.tx_byte = cmd_item.tx_byte;
  assign q_wdata.nack    = cmd_item.nack_after_read;
  assign q_wdata.sda     = cmd_item.sda_level;

endmodule
`default_nettype wire

/* rtl/i2cm_queue.sv */
`default_nettype none
module i2cm_queue #(
  parameter int unsigned DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  input  wire i2cm_pkg::op_t wdata,
  output logic               full,
  input  wire                pop,
  output i2cm_pkg::op_t      rdata,
  output logic               nonempty
);
  import i2cm_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  op_t              slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == FULL_CNT);
  assign nonempty = (count != '0);
  assign rdata    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/i2cm_back.sv */
`default_nettype none
module i2cm_back #(
  parameter int unsigned TIMER_WIDTH = i2cm_pkg::DEF_TIMER_WIDTH
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [i2cm_pkg::HP_WIDTH-1:0]       cfg_data,
  input  wire                                q_nonempty,
  input  wire i2cm_pkg::op_t                 q_rdata,
  output logic                               q_pop,
  output logic                               res_valid,
  input  wire                                res_stall,
  output i2cm_pkg::res_item_t                res_item
);
  import i2cm_pkg::*;

  localparam int unsigned LIM_W = ((TIMER_WIDTH > HP_WIDTH) ? TIMER_WIDTH : HP_WIDTH) + 1;
  localparam logic [LIM_W-1:0] CAP = LIM_W'(1) << TIMER_WIDTH;

  logic [HP_WIDTH-1:0]    half_period;
  phase_t                 phase, phase_next;
  logic [BIT_CNT_W-1:0]   bit_count, bit_count_next;
  logic [7:0]             shift_reg, shift_reg_next;
  logic [TIMER_WIDTH-1:0] tick_timer, tick_timer_next;
  logic [7:0]             rx_reg, rx_reg_next;
  logic                   ack_reg, ack_reg_next;
  logic                   nack_flag, nack_flag_next;
  logic                   scl, scl_next;
  logic                   sda, sda_next;
  logic                   done;

  logic                   step;
  logic                   idle;
  logic                   tick_end;
  logic                   last_bit;
  logic [BIT_CNT_W-1:0]   bit_inc;
  logic [LIM_W-1:0]       limit;
  logic [LIM_W-1:0]       tick_inc;

  function automatic logic [1:0] line_levels(phase_t p, logic msb, logic nk);
    logic [1:0] lv;
    unique case (p)
      PH_ST_A:  lv = 2'b11;
      PH_ST_B:  lv = 2'b10;
      PH_WR_LO: lv = {1'b0, msb};
      PH_WR_HI: lv = {1'b1, msb};
      PH_WA_LO: lv = 2'b01;
      PH_WA_HI: lv = 2'b11;
      PH_RD_LO: lv = 2'b01;
      PH_RD_HI: lv = 2'b11;
      PH_RA_LO: lv = {1'b0, nk};
      PH_RA_HI: lv = {1'b1, nk};
      PH_SP_A:  lv = 2'b00;
      PH_SP_B:  lv = 2'b10;
      PH_SP_C:  lv = 2'b11;
      default:  lv = 2'b00;
    endcase
    return lv;
  endfunction

  assign cfg_ready = 1'b1;
  assign step      = q_nonempty & (~res_valid | ~res_stall);
  assign q_pop     = step;
  assign idle      = (phase == PH_IDLE);
  assign bit_inc   = bit_count + BIT_CNT_W'(1);
  assign last_bit  = (bit_inc >= BITS_PER_BYTE);

  // zero half period counts as one tick, long ones clip at the timer range
  always_comb begin
    limit = LIM_W'(half_period);
    if (half_period == '0) begin
      limit = LIM_W'(1);
    end
    if (limit > CAP) begin
      limit = CAP;
    end
  end

  assign tick_inc = LIM_W'(tick_timer) + LIM_W'(1);
  assign tick_end = (tick_inc >= limit);

  // next phase
  always_comb begin
    phase_next = phase;
    if (step) begin
      if (idle) begin
        unique case (q_rdata.cls)
          CLS_START: phase_next = PH_ST_A;
          CLS_WRITE: phase_next = PH_WR_LO;
          CLS_READ:  phase_next = PH_RD_LO;
          CLS_STOP:  phase_next = PH_SP_A;
          default:   phase_next = PH_IDLE;
        endcase
      end else if (tick_end) begin
        unique case (phase)
          PH_ST_A:  phase_next = PH_ST_B;
          PH_ST_B:  phase_next = PH_WR_LO;
          PH_WR_LO: phase_next = PH_WR_HI;
          PH_WR_HI: phase_next = last_bit ? PH_WA_LO : PH_WR_LO;
          PH_WA_LO: phase_next = PH_WA_HI;
          PH_RD_LO: phase_next = PH_RD_HI;
          PH_RD_HI: phase_next = last_bit ? PH_RA_LO : PH_RD_LO;
          PH_RA_LO: phase_next = PH_RA_HI;
          PH_SP_A:  phase_next = PH_SP_B;
          PH_SP_B:  phase_next = PH_SP_C;
          default:  phase_next = PH_IDLE;
        endcase
      end
    end
  end

  // datapath and line levels
  always_comb begin
    bit_count_next  = bit_count;
    shift_reg_next  = shift_reg;
    tick_timer_next = tick_timer;
    rx_reg_next     = rx_reg;
    ack_reg_next    = ack_reg;
    nack_flag_next  = nack_flag;
    scl_next        = scl;
    sda_next        = sda;
    done            = 1'b0;
    if (step) begin
      if (idle) begin
        tick_timer_next = '0;
        unique case (q_rdata.cls)
          CLS_START, CLS_WRITE: begin
            shift_reg_next = q_rdata.tx_byte;
            bit_count_next = '0;
          end
          CLS_READ: begin
            shift_reg_next = '0;
            bit_count_next = '0;
            nack_flag_next = q_rdata.nack;
          end
          default: ;
        endcase
      end else if (tick_end) begin
        tick_timer_next = '0;
        unique case (phase)
          PH_ST_B: bit_count_next = '0;
          PH_WR_HI: begin
            shift_reg_next = {shift_reg[6:0], 1'b0};
            bit_count_next = bit_inc;
          end
          PH_WA_HI: begin
            ack_reg_next = q_rdata.sda;
            done         = 1'b1;
          end
          PH_RD_HI: begin
            shift_reg_next = {shift_reg[6:0], q_rdata.sda};
            bit_count_next = bit_inc;
            if (last_bit) begin
              rx_reg_next = {shift_reg[6:0], q_rdata.sda};
            end
          end
          PH_RA_HI, PH_SP_C: done = 1'b1;
          default: ;
        endcase
      end else begin
        tick_timer_next = tick_timer + TIMER_WIDTH'(1);
      end

      if (phase_next != PH_IDLE && phase_next != phase) begin
        {scl_next, sda_next} = line_levels(phase_next, shift_reg_next[7], nack_flag_next);
      end else if (!idle && tick_end && (phase == PH_WA_HI || phase == PH_RA_HI)) begin
        // both lines held low after a byte
        {scl_next, sda_next} = 2'b00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= DEF_HALF_PERIOD;
      phase       <= PH_IDLE;
      bit_count   <= '0;
      shift_reg   <= '0;
      tick_timer  <= '0;
      rx_reg      <= '0;
      ack_reg     <= 1'b0;
      nack_flag   <= 1'b0;
      scl         <= 1'b1;
      sda         <= 1'b1;
      res_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        half_period <= cfg_data;
      end
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      shift_reg  <= shift_reg_next;
      tick_timer <= tick_timer_next;
      rx_reg     <= rx_reg_next;
      ack_reg    <= ack_reg_next;
      nack_flag  <= nack_flag_next;
      scl        <= scl_next;
      sda        <= sda_next;
      if (step) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_item.scl_level   <= scl_next;
      res_item.sda_release <= sda_next;
      res_item.busy_res    <= (phase_next != PH_IDLE);
      res_item.done_res    <= done;
      res_item.rx_byte     <= rx_reg_next;
      res_item.ack_bit     <= ack_reg_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/i2c_master_bit_engine_unit.sv */
`default_nettype none
// i2c master bit engine: every request item is one timer tick carrying a command and the sampled
// sda level, and every tick gives exactly one response item with the scl/sda drive, busy, a done
// pulse, the last received byte and the last acknowledge. commands are only taken while idle
// (start plus byte, write byte, read byte, stop; other codes are no-ops), each scl half phase
// lasts half_period_ticks ticks (0 counts as 1), and sda is sampled on the tick that ends an
// scl-high phase. one item is accepted each clock unless the queue is full: the front classifies
// the command and writes it into a four-entry queue, and the back pops one queued tick per cycle
// unless the queue is empty or the response stalls, running the whole phase/timer update in that
// cycle into the response register. while the response stalls, the queue keeps taking items
// until it is full. half_period_ticks is written through the cfg port, always ready.
module i2c_master_bit_engine_unit #(
  parameter int unsigned TIMER_WIDTH = i2cm_pkg::DEF_TIMER_WIDTH,
  parameter int unsigned QDEPTH      = i2cm_pkg::QUEUE_DEPTH
) (
  input  wire                          clk,
  input  wire                          rst,
  // request channel
  input  wire                          cmd_valid,
  output logic                         cmd_stall,
  input  wire i2cm_pkg::cmd_item_t     cmd_item,
  // response channel
  output logic                         res_valid,
  input  wire                          res_stall,
  output i2cm_pkg::res_item_t          res_item,
  // configuration write
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [i2cm_pkg::HP_WIDTH-1:0] cfg_data
);
  import i2cm_pkg::*;

  logic      q_push;
  logic      q_full;
  op_t       q_wdata;
  op_t       q_rdata;
  logic      q_nonempty;
  logic      q_pop;

  // front: classify the command of each tick
  i2cm_front u_front (
    .cmd_item  (cmd_item),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .q_full    (q_full),
    .q_wdata   (q_wdata),
    .q_push    (q_push)
  );

  // short queue so either side can stall alone
  i2cm_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wdata    (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .rdata    (q_rdata),
    .nonempty (q_nonempty)
  );

  // back: phase sequencer, timer, shifter and response register
  i2cm_back #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .q_nonempty (q_nonempty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_item   (res_item)
  );

  // a completed command leaves the engine idle
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_item.done_res && res_item.busy_res))
    else $error("done pulse while still busy");

  // the front never writes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue overflow");

  // the back only pops what is there
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_nonempty)
    else $error("queue underflow");

  // a popped tick always gives a response next cycle
  a_pop_gives_res: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> res_valid)
    else $error("popped tick without response");

endmodule
`default_nettype wire
